/* sv/assert_macros.svh */
// Assertion macros for the RTL of the ID pool allocator.
// Depends on nothing; synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising edge while reset is released.
`define IPA_ASSERT(label, clk_sig, rst_n_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define IPA_ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`else

`define IPA_ASSERT(label, clk_sig, rst_n_sig, prop, msg)
`define IPA_ASSERT_ALWAYS(label, clk_sig, prop, msg)

`endif

`endif

/* sv/ipa_pkg.sv */
// Types, codes and sizes of the ID pool allocator.
// Depends on nothing; ipa_if, ipa_scan_unit and the core import it.
`default_nettype none

package ipa_pkg;

  localparam int POOL_IDS    = 64;
  localparam int ID_W        = $clog2(POOL_IDS);
  localparam int CNT_W       = $clog2(POOL_IDS + 1);
  localparam int OP_W        = 2;
  localparam int IN_ID_W     = 8;
  localparam int GRANT_W     = 6;
  localparam int STATUS_W    = 3;
  localparam int CHUNK_W     = 8;
  localparam int NUM_CHUNKS  = POOL_IDS / CHUNK_W;
  localparam int CHUNK_SEL_W = $clog2(NUM_CHUNKS);
  localparam int OFS_W       = $clog2(CHUNK_W);

  typedef enum logic [OP_W-1:0] {
    OP_RESERVE,
    OP_MARK,
    OP_FREE,
    OP_FREE_ALL
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_POOL_FULL,
    ST_OUT_OF_RANGE,
    ST_NOT_RESERVED,
    ST_ALREADY_RESERVED
  } status_t;

  typedef enum logic {
    STRAT_MARCH,
    STRAT_LOWEST
  } strategy_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PRE,
    S_POST,
    S_RESULT
  } state_t;

  // Command from the sequencer to the search unit.
  typedef struct packed {
    logic            start;
    logic            wrap;
    logic [ID_W-1:0] hint;
  } scan_req_t;

  // Status of the search unit back to the sequencer.
  typedef struct packed {
    logic            busy;
    logic            done;
    logic            found;
    logic [ID_W-1:0] idx;
  } scan_res_t;

endpackage

`default_nettype wire

/* sv/ipa_if.sv */
// Valid/ready channel interfaces of the ID pool allocator.
// Depends on ipa_pkg for the field widths.
`default_nettype none

interface ipa_req_if import ipa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [IN_ID_W-1:0] id;

  modport source (output valid, output op, output id, input ready);
  modport sink   (input valid, input op, input id, output ready);
endinterface

interface ipa_rsp_if import ipa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [GRANT_W-1:0]  granted_id;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink   (input valid, input granted_id, input status, output ready);
endinterface

interface ipa_cfg_if ();
  logic valid;
  logic ready;
  logic strategy;

  modport source (output valid, output strategy, input ready);
  modport sink   (input valid, input strategy, output ready);
endinterface

`default_nettype wire

/* sv/ipa_scan_unit.sv */
// Free-ID search unit: examines one chunk of the free map per cycle.
// Depends on ipa_pkg.
`default_nettype none

module ipa_scan_unit import ipa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [POOL_IDS-1:0] free_map,
  input  scan_req_t           req,
  output scan_res_t           res
);

  logic                   busy_r, busy_nxt;
  logic                   phase_r, phase_nxt;
  logic [CHUNK_SEL_W-1:0] chunk_r, chunk_nxt;
  logic [ID_W-1:0]        hint_r, hint_nxt;
  logic                   wrap_r, wrap_nxt;

  logic [CHUNK_W-1:0]     window;
  logic [CHUNK_W-1:0]     eligible;
  logic [ID_W-1:0]        cand;
  logic                   hit;
  logic [OFS_W-1:0]       hit_ofs;
  logic                   last_chunk;
  logic                   hint_chunk;
  logic                   done;

  // Phase 0 looks above the hint, phase 1 (wrapping searches only) below it.
  always_comb begin
    window   = free_map[{chunk_r, {OFS_W{1'b0}}} +: CHUNK_W];
    eligible = '0;
    cand     = '0;
    for (int j = 0; j < CHUNK_W; j++) begin
      cand        = {chunk_r, OFS_W'(j)};
      eligible[j] = window[j] && (phase_r ? (cand < hint_r) : (cand > hint_r));
    end
    hit     = 1'b0;
    hit_ofs = '0;
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      if (eligible[j]) begin
        hit     = 1'b1;
        hit_ofs = OFS_W'(j);
      end
    end
    last_chunk = (chunk_r == CHUNK_SEL_W'(NUM_CHUNKS - 1));
    hint_chunk = (chunk_r == hint_r[ID_W-1 -: CHUNK_SEL_W]);
    done       = busy_r && (hit || (phase_r ? hint_chunk : (last_chunk && !wrap_r)));

    res.busy  = busy_r;
    res.done  = done;
    res.found = hit;
    res.idx   = {chunk_r, hit_ofs};

    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    chunk_nxt = chunk_r;
    hint_nxt  = hint_r;
    wrap_nxt  = wrap_r;
    if (busy_r) begin
      if (done) begin
        busy_nxt = 1'b0;
      end else if (!phase_r && last_chunk) begin
        phase_nxt = 1'b1;
        chunk_nxt = '0;
      end else begin
        chunk_nxt = chunk_r + 1'b1;
      end
    end
    if (req.start) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
      chunk_nxt = req.hint[ID_W-1 -: CHUNK_SEL_W];
      hint_nxt  = req.hint;
      wrap_nxt  = req.wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    phase_r <= phase_nxt;
    chunk_r <= chunk_nxt;
    hint_r  <= hint_nxt;
    wrap_r  <= wrap_nxt;
  end

endmodule

`default_nettype wire

/* sv/id_pool_allocator_core.sv */
// Top level of the ID pool allocator: sequencer, pool state and result register.
// Depends on ipa_pkg, the channel interfaces in ipa_if and ipa_scan_unit.
//
//   Channel   Modport  Direction  Contents
//   in_req    sink     in         op, id (one request)
//   out_rsp   source   out        granted_id, status (one result per request)
//   cfg_wr    sink     in         strategy (0 march forward, 1 reuse lowest)
//
// Mark, free, free-all and pool-full reserve requests pass from idle straight to the
// result state; a mark that moves a hint adds a search. Other reserves run up to two
// searches (a stale-hint search before the grant, a hint advance after it), each
// examining one 8-ID chunk per cycle in the shared search unit.
// Synchronous active-low reset empties the pool, zeroes both hints and selects
// march forward. A new request is taken while the previous result still waits.
`default_nettype none
`include "assert_macros.svh"

module id_pool_allocator_core import ipa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ipa_req_if.sink   in_req,
  ipa_rsp_if.source out_rsp,
  ipa_cfg_if.sink   cfg_wr
);

  state_t              state_r, state_nxt;
  strategy_t           strategy_r, strategy_nxt;
  logic [POOL_IDS-1:0] reserved_map_r, reserved_map_nxt;
  logic [CNT_W-1:0]    reserved_total_r, reserved_total_nxt;
  logic [ID_W-1:0]     march_hint_r, march_hint_nxt;
  logic [ID_W-1:0]     lowest_hint_r, lowest_hint_nxt;

  // Result under construction, then the output register facing the consumer.
  logic [ID_W-1:0]     res_granted_r, res_granted_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [GRANT_W-1:0]  out_granted_r, out_granted_nxt;
  status_t             out_status_r, out_status_nxt;

  scan_req_t           scan_req;
  scan_res_t           scan_res;

  op_t                 req_op;
  logic                req_in_range;
  logic [ID_W-1:0]     req_idx;
  logic                pool_full;
  logic [ID_W-1:0]     cur_hint;
  logic [ID_W-1:0]     grant_idx;

  ipa_scan_unit u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .free_map (~reserved_map_r),
    .req      (scan_req),
    .res      (scan_res)
  );

  assign in_req.ready       = (state_r == S_IDLE);
  assign cfg_wr.ready       = 1'b1;
  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.granted_id = out_granted_r;
  assign out_rsp.status     = out_status_r;

  always_comb begin
    req_op       = op_t'(in_req.op);
    req_in_range = (int'(in_req.id) < POOL_IDS);
    req_idx      = in_req.id[ID_W-1:0];
    pool_full    = (reserved_total_r == CNT_W'(POOL_IDS));
    // The hint that belongs to the active search policy.
    cur_hint     = (strategy_r == STRAT_LOWEST) ? lowest_hint_r : march_hint_r;
    // A search before the grant always finds a free ID, since the pool is not full.
    grant_idx    = scan_res.found ? scan_res.idx : cur_hint;

    state_nxt          = state_r;
    strategy_nxt       = strategy_r;
    reserved_map_nxt   = reserved_map_r;
    reserved_total_nxt = reserved_total_r;
    march_hint_nxt     = march_hint_r;
    lowest_hint_nxt    = lowest_hint_r;
    res_granted_nxt    = res_granted_r;
    res_status_nxt     = res_status_r;
    out_valid_nxt      = out_valid_r;
    out_granted_nxt    = out_granted_r;
    out_status_nxt     = out_status_r;
    scan_req           = '0;

    if (cfg_wr.valid) begin
      strategy_nxt = strategy_t'(cfg_wr.strategy);
    end

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          res_granted_nxt = '0;
          res_status_nxt  = ST_OK;
          state_nxt       = S_RESULT;
          case (req_op)
            OP_RESERVE: begin
              if (pool_full) begin
                res_status_nxt = ST_POOL_FULL;
              end else if (reserved_map_r[cur_hint]) begin
                // Stale hint: find the next free ID past it, wrapping around.
                scan_req.start = 1'b1;
                scan_req.wrap  = 1'b1;
                scan_req.hint  = cur_hint;
                state_nxt      = S_PRE;
              end else begin
                reserved_map_nxt[cur_hint] = 1'b1;
                reserved_total_nxt         = reserved_total_r + 1'b1;
                res_granted_nxt            = cur_hint;
                scan_req.start             = 1'b1;
                scan_req.wrap              = (strategy_r == STRAT_MARCH);
                scan_req.hint              = cur_hint;
                state_nxt                  = S_POST;
              end
            end
            OP_MARK: begin
              if (!req_in_range) begin
                res_status_nxt = ST_OUT_OF_RANGE;
              end else if (reserved_map_r[req_idx]) begin
                res_status_nxt = ST_ALREADY_RESERVED;
              end else begin
                reserved_map_nxt[req_idx] = 1'b1;
                reserved_total_nxt        = reserved_total_r + 1'b1;
                // The march hint moves on when the marked ID is at or past it;
                // the lowest hint only when the marked ID is the hint itself.
                if (strategy_r == STRAT_MARCH && req_idx >= march_hint_r) begin
                  scan_req.start = 1'b1;
                  scan_req.wrap  = 1'b1;
                  scan_req.hint  = march_hint_r;
                  state_nxt      = S_POST;
                end else if (strategy_r == STRAT_LOWEST && req_idx == lowest_hint_r) begin
                  scan_req.start = 1'b1;
                  scan_req.wrap  = 1'b0;
                  scan_req.hint  = lowest_hint_r;
                  state_nxt      = S_POST;
                end
              end
            end
            OP_FREE: begin
              if (!req_in_range) begin
                res_status_nxt = ST_OUT_OF_RANGE;
              end else if (!reserved_map_r[req_idx]) begin
                res_status_nxt = ST_NOT_RESERVED;
              end else begin
                reserved_map_nxt[req_idx] = 1'b0;
                reserved_total_nxt        = reserved_total_r - 1'b1;
                if (strategy_r == STRAT_LOWEST && req_idx < lowest_hint_r) begin
                  lowest_hint_nxt = req_idx;
                end
              end
            end
            OP_FREE_ALL: begin
              reserved_map_nxt   = '0;
              reserved_total_nxt = '0;
              march_hint_nxt     = '0;
              lowest_hint_nxt    = '0;
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_PRE: begin
        if (scan_res.done) begin
          // Move the hint onto the free ID, hand it out, then advance past it.
          if (strategy_r == STRAT_LOWEST) begin
            lowest_hint_nxt = grant_idx;
          end else begin
            march_hint_nxt = grant_idx;
          end
          reserved_map_nxt[grant_idx] = 1'b1;
          reserved_total_nxt          = reserved_total_r + 1'b1;
          res_granted_nxt             = grant_idx;
          scan_req.start              = 1'b1;
          scan_req.wrap               = (strategy_r == STRAT_MARCH);
          scan_req.hint               = grant_idx;
          state_nxt                   = S_POST;
        end
      end

      S_POST: begin
        if (scan_res.done) begin
          // With nothing free beyond the hint, the hint stays put.
          if (scan_res.found) begin
            if (strategy_r == STRAT_LOWEST) begin
              lowest_hint_nxt = scan_res.idx;
            end else begin
              march_hint_nxt = scan_res.idx;
            end
          end
          state_nxt = S_RESULT;
        end
      end

      S_RESULT: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = GRANT_W'(res_granted_r);
          out_status_nxt  = res_status_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      strategy_r       <= STRAT_MARCH;
      reserved_map_r   <= '0;
      reserved_total_r <= '0;
      march_hint_r     <= '0;
      lowest_hint_r    <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      strategy_r       <= strategy_nxt;
      reserved_map_r   <= reserved_map_nxt;
      reserved_total_r <= reserved_total_nxt;
      march_hint_r     <= march_hint_nxt;
      lowest_hint_r    <= lowest_hint_nxt;
      out_valid_r      <= out_valid_nxt;
    end
    res_granted_r <= res_granted_nxt;
    res_status_r  <= res_status_nxt;
    out_granted_r <= out_granted_nxt;
    out_status_r  <= out_status_nxt;
  end

  // The count of reserved IDs always agrees with the bitmap.
  `IPA_ASSERT(a_total_matches_map, clk, rst_n, reserved_total_r == CNT_W'($countones(reserved_map_r)), "reserved count differs from bitmap population")

  // The search unit only runs while the sequencer waits on it.
  `IPA_ASSERT(a_scan_only_in_search, clk, rst_n, scan_res.busy |-> (state_r == S_PRE || state_r == S_POST), "search unit busy outside a search state")

  // A finished result is held back, not dropped, while the output slot is taken.
  `IPA_ASSERT(a_result_waits_for_slot, clk, rst_n, (state_r == S_RESULT && out_valid_r && !out_rsp.ready) |=> (state_r == S_RESULT), "result left the sequencer while the output was stalled")

endmodule

`default_nettype wire
